@@ src/atsd_pkg.sv @@
package atsd_pkg;

  localparam int THR_BITS     = 13;
  localparam int ADJ_BITS     = 8;
  localparam int CFG_IDX_BITS = 3;

  // Amount by which a change must exceed its threshold before the threshold adapts.
  localparam int OVERSHOOT_MARGIN = 200;

  localparam logic [THR_BITS-1:0] X_THR_RST    = THR_BITS'(35);
  localparam logic [THR_BITS-1:0] YZ_MIN_RST   = THR_BITS'(175);
  localparam logic [THR_BITS-1:0] YZ_MAX_RST   = THR_BITS'(195);
  localparam logic [ADJ_BITS-1:0] ADJ_RST      = ADJ_BITS'(2);
  localparam logic [THR_BITS-1:0] INIT_THR_RST = THR_BITS'(185);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_X_THR    = 3'd0,
    CFG_YZ_MIN   = 3'd1,
    CFG_YZ_MAX   = 3'd2,
    CFG_ADJ_STEP = 3'd3,
    CFG_INIT_THR = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [THR_BITS-1:0] thr_min;
    logic [THR_BITS-1:0] thr_max;
    logic [ADJ_BITS-1:0] adj_step;
  } yz_lim_t;

endpackage

@@ src/atsd_lane.sv @@
module atsd_lane #(
  parameter int SAMPLE_BITS = 13
) (
  input  logic signed [SAMPLE_BITS-1:0]   cur_i,
  input  logic signed [SAMPLE_BITS-1:0]   prev_i,
  input  logic [atsd_pkg::THR_BITS-1:0]   thr_i,
  output logic [SAMPLE_BITS-1:0]          change_o,
  output logic                            pass_o
);
  import atsd_pkg::*;

  localparam int CW = ((SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS) + 1;

  logic signed [SAMPLE_BITS:0] cur_e;
  logic signed [SAMPLE_BITS:0] prev_e;
  logic signed [SAMPLE_BITS:0] mag_cur;
  logic signed [SAMPLE_BITS:0] mag_prev;
  logic signed [SAMPLE_BITS:0] diff;
  logic signed [SAMPLE_BITS:0] diff_abs;
  logic [CW-1:0]               change_w;
  logic [CW-1:0]               thr_w;

  assign cur_e    = {cur_i[SAMPLE_BITS-1], cur_i};
  assign prev_e   = {prev_i[SAMPLE_BITS-1], prev_i};
  assign mag_cur  = cur_e[SAMPLE_BITS] ? -cur_e : cur_e;
  assign mag_prev = prev_e[SAMPLE_BITS] ? -prev_e : prev_e;
  assign diff     = mag_cur - mag_prev;
  assign diff_abs = diff[SAMPLE_BITS] ? -diff : diff;

  // The magnitude difference never exceeds half the sample range, so it fits unsigned.
  assign change_o = diff_abs[SAMPLE_BITS-1:0];
  assign change_w = CW'(change_o);
  assign thr_w    = CW'(thr_i);
  assign pass_o   = (change_w >= thr_w);

endmodule

@@ src/atsd_thr_adapt.sv @@
module atsd_thr_adapt #(
  parameter int SAMPLE_BITS = 13
) (
  input  logic [SAMPLE_BITS-1:0]          change_i,
  input  logic                            pass_i,
  input  logic [atsd_pkg::THR_BITS-1:0]   thr_i,
  input  atsd_pkg::yz_lim_t               lim_i,
  output logic [atsd_pkg::THR_BITS-1:0]   thr_nxt_o
);
  import atsd_pkg::*;

  localparam int CW = ((SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS) + 1;

  logic [CW-1:0]       excess;
  logic                overshoot;
  logic [THR_BITS-1:0] clamped;
  logic [THR_BITS:0]   raised;
  logic [THR_BITS-1:0] adjusted;

  // Only meaningful when the axis passes, in which case it is never negative.
  assign excess    = CW'(change_i) - CW'(thr_i);
  assign overshoot = pass_i && (excess > CW'(OVERSHOOT_MARGIN));

  // The upper bound is checked first: with min above max, a threshold above max goes to max.
  always_comb begin
    if (thr_i > lim_i.thr_max) begin
      clamped = lim_i.thr_max;
    end else if (thr_i < lim_i.thr_min) begin
      clamped = lim_i.thr_min;
    end else begin
      clamped = thr_i;
    end
  end

  assign raised = {1'b0, clamped} + (THR_BITS + 1)'(lim_i.adj_step);

  always_comb begin
    if (clamped < lim_i.thr_max) begin
      adjusted = raised[THR_BITS] ? {THR_BITS{1'b1}} : raised[THR_BITS-1:0];
    end else begin
      adjusted = clamped;
    end
  end

  assign thr_nxt_o = overshoot ? adjusted : thr_i;

endmodule

@@ src/atsd_merge.sv @@
module atsd_merge #(
  parameter int COUNT_BITS = 24
) (
  input  logic                  primed_i,
  input  logic                  pass_x_i,
  input  logic                  pass_y_i,
  input  logic                  pass_z_i,
  input  logic                  vibrating_i,
  input  logic [COUNT_BITS-1:0] count_i,
  output logic                  step_o,
  output logic [COUNT_BITS-1:0] count_nxt_o
);
  import atsd_pkg::*;

  assign step_o = primed_i && pass_x_i && (pass_y_i || pass_z_i) && !vibrating_i;

  // The counter holds at all ones once full.
  assign count_nxt_o = (step_o && (count_i != {COUNT_BITS{1'b1}})) ?
                       count_i + COUNT_BITS'(1) : count_i;

endmodule

@@ src/adaptive_threshold_step_detector.sv @@
// Step detector for a three-axis accelerometer stream. Each accepted sample yields exactly one
// result, registered at the transfer: the step flag, the saturating step total and
// the Y and Z thresholds as they stand after that sample. The first sample after reset only
// primes the stored previous sample and never counts. A new sample is taken every cycle while
// in_ready is high; the three axis lanes and the threshold update all settle within that cycle,
// which is what sets the one-sample-per-cycle rate. An output register backed by a one-entry
// skid buffer lets two results wait, so in_ready falls only when both are held. Configuration
// writes take effect at once; writing the initial threshold also reloads both adaptive thresholds.
module adaptive_threshold_step_detector #(
  parameter int SAMPLE_BITS = 13,
  parameter int COUNT_BITS  = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [SAMPLE_BITS-1:0]        in_accel_x,
  input  logic signed [SAMPLE_BITS-1:0]        in_accel_y,
  input  logic signed [SAMPLE_BITS-1:0]        in_accel_z,
  input  logic                                 in_vibrating,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_step_detected,
  output logic [COUNT_BITS-1:0]                out_step_total,
  output logic [atsd_pkg::THR_BITS-1:0]        out_y_threshold_now,
  output logic [atsd_pkg::THR_BITS-1:0]        out_z_threshold_now,
  input  logic                                 cfg_wr_en,
  input  logic [atsd_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [atsd_pkg::THR_BITS-1:0]        cfg_data
);
  import atsd_pkg::*;

  localparam int RES_W = 1 + COUNT_BITS + 2 * THR_BITS;

  logic [THR_BITS-1:0] x_thr_r;
  logic [THR_BITS-1:0] yz_min_r;
  logic [THR_BITS-1:0] yz_max_r;
  logic [ADJ_BITS-1:0] adj_r;

  logic                          primed_r;
  logic signed [SAMPLE_BITS-1:0] prev_x_r;
  logic signed [SAMPLE_BITS-1:0] prev_y_r;
  logic signed [SAMPLE_BITS-1:0] prev_z_r;
  logic [THR_BITS-1:0]           y_thr_r;
  logic [THR_BITS-1:0]           z_thr_r;
  logic [COUNT_BITS-1:0]         count_r;

  logic             out_valid_r;
  logic [RES_W-1:0] out_data_r;
  logic             skid_valid_r;
  logic [RES_W-1:0] skid_data_r;

  logic                   accept;
  logic                   init_wr;
  yz_lim_t                lim;
  logic [SAMPLE_BITS-1:0] chg_x;
  logic [SAMPLE_BITS-1:0] chg_y;
  logic [SAMPLE_BITS-1:0] chg_z;
  logic                   pass_x;
  logic                   pass_y;
  logic                   pass_z;
  logic [THR_BITS-1:0]    y_thr_adapt;
  logic [THR_BITS-1:0]    z_thr_adapt;
  logic [THR_BITS-1:0]    y_thr_nxt;
  logic [THR_BITS-1:0]    z_thr_nxt;
  logic                   step;
  logic [COUNT_BITS-1:0]  count_nxt;
  logic [RES_W-1:0]       res;

  assign in_ready = !skid_valid_r;
  assign accept   = in_valid && in_ready;
  assign init_wr  = cfg_wr_en && (cfg_index == CFG_INIT_THR);

  assign lim.thr_min  = yz_min_r;
  assign lim.thr_max  = yz_max_r;
  assign lim.adj_step = adj_r;

  atsd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
    .cur_i(in_accel_x), .prev_i(prev_x_r), .thr_i(x_thr_r),
    .change_o(chg_x), .pass_o(pass_x)
  );

  atsd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
    .cur_i(in_accel_y), .prev_i(prev_y_r), .thr_i(y_thr_r),
    .change_o(chg_y), .pass_o(pass_y)
  );

  atsd_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
    .cur_i(in_accel_z), .prev_i(prev_z_r), .thr_i(z_thr_r),
    .change_o(chg_z), .pass_o(pass_z)
  );

  atsd_thr_adapt #(.SAMPLE_BITS(SAMPLE_BITS)) u_adapt_y (
    .change_i(chg_y), .pass_i(pass_y), .thr_i(y_thr_r), .lim_i(lim),
    .thr_nxt_o(y_thr_adapt)
  );

  atsd_thr_adapt #(.SAMPLE_BITS(SAMPLE_BITS)) u_adapt_z (
    .change_i(chg_z), .pass_i(pass_z), .thr_i(z_thr_r), .lim_i(lim),
    .thr_nxt_o(z_thr_adapt)
  );

  atsd_merge #(.COUNT_BITS(COUNT_BITS)) u_merge (
    .primed_i(primed_r), .pass_x_i(pass_x), .pass_y_i(pass_y), .pass_z_i(pass_z),
    .vibrating_i(in_vibrating), .count_i(count_r),
    .step_o(step), .count_nxt_o(count_nxt)
  );

  // The priming sample leaves the thresholds alone; chg_x is unused beyond its compare.
  assign y_thr_nxt = primed_r ? y_thr_adapt : y_thr_r;
  assign z_thr_nxt = primed_r ? z_thr_adapt : z_thr_r;
  assign res       = {step, count_nxt, y_thr_nxt, z_thr_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_thr_r    <= X_THR_RST;
      yz_min_r   <= YZ_MIN_RST;
      yz_max_r   <= YZ_MAX_RST;
      adj_r      <= ADJ_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_X_THR:    x_thr_r    <= cfg_data;
        CFG_YZ_MIN:   yz_min_r   <= cfg_data;
        CFG_YZ_MAX:   yz_max_r   <= cfg_data;
        CFG_ADJ_STEP: adj_r      <= cfg_data[ADJ_BITS-1:0];
        // The initial threshold only matters through the reload of both thresholds below.
        CFG_INIT_THR: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r <= 1'b0;
      prev_x_r <= '0;
      prev_y_r <= '0;
      prev_z_r <= '0;
      y_thr_r  <= INIT_THR_RST;
      z_thr_r  <= INIT_THR_RST;
      count_r  <= '0;
    end else if (init_wr) begin
      y_thr_r <= cfg_data;
      z_thr_r <= cfg_data;
    end else if (accept) begin
      primed_r <= 1'b1;
      prev_x_r <= in_accel_x;
      prev_y_r <= in_accel_y;
      prev_z_r <= in_accel_z;
      y_thr_r  <= y_thr_nxt;
      z_thr_r  <= z_thr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_r || out_ready) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ready) begin
        out_data_r <= skid_data_r;
      end
    end else if (accept) begin
      if (!out_valid_r || out_ready) begin
        out_data_r <= res;
      end else begin
        skid_data_r <= res;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_step_detected   = out_data_r[RES_W-1];
  assign out_step_total      = out_data_r[2*THR_BITS +: COUNT_BITS];
  assign out_y_threshold_now = out_data_r[THR_BITS +: THR_BITS];
  assign out_z_threshold_now = out_data_r[0 +: THR_BITS];

`ifndef SYNTHESIS
  // A result in the skid buffer always sits behind one in the output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid buffer holds a result while the output register is empty");

  // The priming transfer never reports a step.
  a_prime_no_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !primed_r && !out_valid_r) |=> (out_valid_r && !out_step_detected))
    else $error("priming sample reported a step");

  // The step counter only ever grows.
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r >= $past(count_r)))
    else $error("step counter decreased");

  // Thresholds move only on a sample transfer or a reload of the initial value.
  a_thr_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!accept && !init_wr) |=> ($stable(y_thr_r) && $stable(z_thr_r)))
    else $error("adaptive threshold changed without a transfer or reload");
`endif

endmodule

@@ tb/adaptive_threshold_step_detector_tb.sv @@
module adaptive_threshold_step_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import atsd_pkg::*;

  localparam int SB = 13;
  localparam int CB = 24;
  localparam int LIMIT_CYCLES = 100000;
  localparam int SAMPLE_MAX = 4095;
  localparam int PHASE_ITEMS = 200;
  localparam int PHASES = 8;
  localparam int QUIET_PHASE = 4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FIRST_SPARE = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LAST_SPARE = '1;
  localparam logic [THR_BITS-1:0] THR_FULL = '1;
  localparam logic [ADJ_BITS-1:0] ADJ_FULL = '1;

  typedef struct packed {
    logic                step;
    logic [CB-1:0]       total;
    logic [THR_BITS-1:0] y_thr;
    logic [THR_BITS-1:0] z_thr;
  } step_report_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [SB-1:0]     in_accel_x = '0;
  logic signed [SB-1:0]     in_accel_y = '0;
  logic signed [SB-1:0]     in_accel_z = '0;
  logic                     in_vibrating = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_step_detected;
  logic [CB-1:0]            out_step_total;
  logic [THR_BITS-1:0]      out_y_threshold_now;
  logic [THR_BITS-1:0]      out_z_threshold_now;
  logic                     cfg_wr_en = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_X_THR;
  logic [THR_BITS-1:0]      cfg_data = '0;

  // Register copies and detector state as the block should hold them.
  logic [THR_BITS-1:0] x_thr_cfg = X_THR_RST;
  logic [THR_BITS-1:0] yz_min_cfg = YZ_MIN_RST;
  logic [THR_BITS-1:0] yz_max_cfg = YZ_MAX_RST;
  logic [ADJ_BITS-1:0] adj_cfg = ADJ_RST;
  logic [THR_BITS-1:0] y_thr_track = INIT_THR_RST;
  logic [THR_BITS-1:0] z_thr_track = INIT_THR_RST;
  logic [CB-1:0]       step_count_track = '0;
  bit                  primed_seen = 1'b0;
  int                  prev_x = 0;
  int                  prev_y = 0;
  int                  prev_z = 0;

  step_report_t pending_reports[$];

  bit idle_on = 1'b1;
  int hold_left = 0;
  int last_x = 0;
  int last_y = 0;
  int last_z = 0;
  int failures = 0;
  int samples_sent = 0;
  int results_checked = 0;
  int steps_seen = 0;
  int adaptations = 0;
  int register_writes = 0;
  int cycle_count = 0;

  adaptive_threshold_step_detector uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_accel_x          (in_accel_x),
    .in_accel_y          (in_accel_y),
    .in_accel_z          (in_accel_z),
    .in_vibrating        (in_vibrating),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_step_detected   (out_step_detected),
    .out_step_total      (out_step_total),
    .out_y_threshold_now (out_y_threshold_now),
    .out_z_threshold_now (out_z_threshold_now),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #1 clk = ~clk;

  function automatic int magnitude(input int v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic int axis_change(input int cur, input int prv);
    return magnitude(magnitude(cur) - magnitude(prv));
  endfunction

  // A large overshoot first pulls the threshold into min..max (max checked first),
  // then raises it by the adjust step while it is still below max.
  function automatic bit axis_passes(input int change, inout logic [THR_BITS-1:0] thr);
    int t;
    t = int'(thr);
    if (change < t) return 1'b0;
    if (change - t > OVERSHOOT_MARGIN) begin
      if (t > int'(yz_max_cfg)) begin
        t = int'(yz_max_cfg);
      end else if (t < int'(yz_min_cfg)) begin
        t = int'(yz_min_cfg);
      end
      if (t < int'(yz_max_cfg)) begin
        t = t + int'(adj_cfg);
        if (t > int'(THR_FULL)) t = int'(THR_FULL);
      end
      if (t != int'(thr)) adaptations++;
      thr = t[THR_BITS-1:0];
    end
    return 1'b1;
  endfunction

  function automatic step_report_t detect_step(input int x, input int y, input int z,
                                               input bit vib);
    step_report_t r;
    bit x_ok;
    bit y_ok;
    bit z_ok;
    r.step = 1'b0;
    if (primed_seen) begin
      x_ok = axis_change(x, prev_x) >= int'(x_thr_cfg);
      y_ok = axis_passes(axis_change(y, prev_y), y_thr_track);
      z_ok = axis_passes(axis_change(z, prev_z), z_thr_track);
      r.step = x_ok && (y_ok || z_ok) && !vib;
      if (r.step && step_count_track != '1) step_count_track++;
    end else begin
      primed_seen = 1'b1;
    end
    prev_x = x;
    prev_y = y;
    prev_z = z;
    r.total = step_count_track;
    r.y_thr = y_thr_track;
    r.z_thr = z_thr_track;
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
      failures++;
    end
  endfunction

  function automatic int nudge(input int prv, input int spread);
    int m;
    int v;
    m = magnitude(prv);
    if ($urandom_range(0, 1) == 1) begin
      m = m + $urandom_range(0, spread);
    end else begin
      m = m - $urandom_range(0, spread);
    end
    m = magnitude(m);
    if (m > SAMPLE_MAX + 1) m = SAMPLE_MAX + 1;
    v = ($urandom_range(0, 1) == 1) ? -m : m;
    if (v > SAMPLE_MAX) v = SAMPLE_MAX;
    return v;
  endfunction

  function automatic logic [THR_BITS-1:0] pick_threshold(input int typical_hi);
    int r;
    r = $urandom_range(0, 11);
    if (r == 0) return '0;
    if (r == 1) return THR_FULL;
    return THR_BITS'($urandom_range(0, typical_hi));
  endfunction

  // Register writes are only issued with the input idle and every result collected.
  task automatic apply_register(input logic [CFG_IDX_BITS-1:0] idx,
                                input logic [THR_BITS-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      CFG_X_THR:    x_thr_cfg = data;
      CFG_YZ_MIN:   yz_min_cfg = data;
      CFG_YZ_MAX:   yz_max_cfg = data;
      CFG_ADJ_STEP: adj_cfg = data[ADJ_BITS-1:0];
      CFG_INIT_THR: begin
        y_thr_track = data;
        z_thr_track = data;
      end
      default: ;
    endcase
    register_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_sample(input logic signed [SB-1:0] x, input logic signed [SB-1:0] y,
                             input logic signed [SB-1:0] z, input logic vib);
    int gap;
    if (idle_on && $urandom_range(0, 99) < 7) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_accel_x   <= x;
    in_accel_y   <= y;
    in_accel_z   <= z;
    in_vibrating <= vib;
    do @(posedge clk); while (!in_ready);
    pending_reports.push_back(detect_step(int'(x), int'(y), int'(z), vib));
    samples_sent++;
  endtask

  task automatic send_random_sample;
    int kind;
    int spread;
    logic signed [SB-1:0] x;
    logic signed [SB-1:0] y;
    logic signed [SB-1:0] z;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      x = SB'($urandom);
      y = SB'($urandom);
      z = SB'($urandom);
    end else begin
      // Mostly walks around the previous magnitude so that changes land near the thresholds.
      spread = (kind < 8) ? 450 : 40;
      x = SB'(nudge(last_x, spread));
      y = SB'(nudge(last_y, spread));
      z = SB'(nudge(last_z, spread));
    end
    last_x = int'(x);
    last_y = int'(y);
    last_z = int'(z);
    send_sample(x, y, z, $urandom_range(0, 3) == 0);
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Alternating large swings on every axis, enough to pass and overshoot most thresholds.
  task automatic swing(input int n);
    for (int i = 0; i < n; i++) begin
      send_sample(SB'((i % 2 == 1) ? 40 : -3000), SB'((i % 2 == 1) ? 4000 : 0),
                  SB'((i % 2 == 1) ? 0 : -4000), 1'b0);
    end
    drain;
  endtask

  task automatic restore_defaults;
    apply_register(CFG_X_THR, X_THR_RST);
    apply_register(CFG_YZ_MIN, YZ_MIN_RST);
    apply_register(CFG_YZ_MAX, YZ_MAX_RST);
    apply_register(CFG_ADJ_STEP, THR_BITS'(ADJ_RST));
    apply_register(CFG_INIT_THR, INIT_THR_RST);
  endtask

  task automatic test_priming_and_edges;
    send_sample(0, 0, 0, 1'b0);
    send_sample(35, 185, 0, 1'b0);
    send_sample(0, -385, 0, 1'b0);
    send_sample(34, 0, 386, 1'b0);
    send_sample(-4096, 4095, -4096, 1'b0);
    send_sample(4095, -4096, 4095, 1'b1);
    send_sample(-1, -1, -1, 1'b0);
    send_sample(-4096, -4096, -4096, 1'b0);
    send_sample(0, 0, 0, 1'b1);
    drain;
  endtask

  task automatic test_threshold_clamping;
    apply_register(CFG_YZ_MIN, 300);
    apply_register(CFG_YZ_MAX, 100);
    apply_register(CFG_INIT_THR, 185);
    swing(3);
    apply_register(CFG_INIT_THR, 50);
    swing(3);
    apply_register(CFG_YZ_MIN, 175);
    apply_register(CFG_YZ_MAX, 195);
    swing(3);
    // Only the low byte of the data reaches the adjust step.
    apply_register(CFG_YZ_MAX, THR_FULL);
    apply_register(CFG_ADJ_STEP, THR_FULL);
    swing(4);
    apply_register(CFG_ADJ_STEP, '0);
    apply_register(CFG_YZ_MIN, '0);
    apply_register(CFG_INIT_THR, '0);
    swing(2);
    apply_register(CFG_INIT_THR, THR_FULL);
    swing(2);
    restore_defaults();
  endtask

  task automatic test_x_threshold_extremes;
    apply_register(CFG_X_THR, '0);
    swing(2);
    apply_register(CFG_X_THR, THR_FULL);
    swing(2);
    restore_defaults();
  endtask

  task automatic test_spare_indexes;
    for (int i = int'(CFG_FIRST_SPARE); i <= int'(CFG_LAST_SPARE); i++) begin
      apply_register(i[CFG_IDX_BITS-1:0], THR_BITS'($urandom));
    end
    swing(2);
  endtask

  task automatic test_output_backpressure;
    idle_on = 1'b0;
    hold_left = 80;
    repeat (40) send_random_sample();
    drain;
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic;
    for (int p = 0; p < PHASES; p++) begin
      apply_register(CFG_X_THR, pick_threshold(150));
      apply_register(CFG_YZ_MIN, pick_threshold(400));
      apply_register(CFG_YZ_MAX, pick_threshold(450));
      case ($urandom_range(0, 5))
        0: apply_register(CFG_ADJ_STEP, '0);
        1: apply_register(CFG_ADJ_STEP, THR_BITS'(ADJ_FULL));
        default: apply_register(CFG_ADJ_STEP, THR_BITS'($urandom_range(0, 40)));
      endcase
      apply_register(CFG_INIT_THR, pick_threshold(600));
      // One phase runs without any idling on either side.
      idle_on = (p != QUIET_PHASE);
      repeat (PHASE_ITEMS) send_random_sample();
      drain;
    end
    idle_on = 1'b1;
  endtask

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= !(idle_on && $urandom_range(0, 99) < 7);
    end
  end

  always @(posedge clk) begin : check_report
    step_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result, actual step %0b total %0d y %0d z %0d", $realtime,
                 out_step_detected, out_step_total, out_y_threshold_now, out_z_threshold_now);
        failures++;
      end else begin
        want = pending_reports.pop_front();
        check_field("step_detected", want.step, out_step_detected);
        check_field("step_total", want.total, out_step_total);
        check_field("y_threshold_now", want.y_thr, out_y_threshold_now);
        check_field("z_threshold_now", want.z_thr, out_z_threshold_now);
        results_checked++;
        if (out_step_detected) steps_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timed out with %0d results outstanding", $realtime,
               pending_reports.size());
      $display("FAIL adaptive_threshold_step_detector");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_priming_and_edges();
    test_threshold_clamping();
    test_x_threshold_extremes();
    test_spare_indexes();
    test_output_backpressure();
    test_random_traffic();
    if (pending_reports.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $realtime, pending_reports.size());
      failures++;
    end
    $display("Checked %0d results from %0d samples across %0d register writes.",
             results_checked, samples_sent, register_writes);
    $display("Steps counted: %0d; adaptive threshold moves: %0d; one long output hold-off.",
             steps_seen, adaptations);
    if (failures == 0) begin
      $display("PASS adaptive_threshold_step_detector");
    end else begin
      $display("FAIL adaptive_threshold_step_detector");
    end
    $finish;
  end

endmodule
